### rtl/ued_pkg.sv
// ---------------------------------------------------------------------------
// ued_pkg
// Shared types, constants and helper functions of the URL / C escape decoder.
// ---------------------------------------------------------------------------
`default_nettype none

package ued_pkg;

  localparam int unsigned CmdQueueDepth = 4;

  localparam logic [1:0] ModeCopy = 2'd0;
  localparam logic [1:0] ModeUrl  = 2'd1;
  localparam logic [1:0] ModeC    = 2'd2;

  localparam logic [7:0] ChPlus      = 8'h2B;
  localparam logic [7:0] ChPercent   = 8'h25;
  localparam logic [7:0] ChSpace     = 8'h20;
  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChX         = 8'h78;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } ued_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       out_last;
  } ued_out_t;

  typedef struct packed {
    logic     two;
    ued_out_t first;
    ued_out_t second;
  } ued_cmd_t;

  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [3:0] v;
    v = 4'd0;
    if (c inside {[8'h41:8'h46]}) v = 4'(c - 8'h37);
    else if (c inside {[8'h61:8'h66]}) v = 4'(c - 8'h57);
    else if (c inside {[8'h30:8'h39]}) v = 4'(c - 8'h30);
    return v;
  endfunction

  function automatic logic [7:0] c_escape_map(input logic [7:0] c);
    logic [7:0] v;
    case (c)
      8'h61:   v = 8'd7;
      8'h62:   v = 8'd8;
      8'h66:   v = 8'd12;
      8'h6E:   v = 8'd10;
      8'h72:   v = 8'd13;
      8'h74:   v = 8'd9;
      8'h76:   v = 8'd11;
      8'h30:   v = 8'd0;
      default: v = c;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] url_plain(input logic [7:0] c);
    return (c == ChPlus) ? ChSpace : c;
  endfunction

endpackage

`default_nettype wire

### rtl/ued_front.sv
// ---------------------------------------------------------------------------
// ued_front
// Classifies each input byte against the escape state and the mode register
// and produces a command of zero, one or two results.
// ---------------------------------------------------------------------------
`default_nettype none

module ued_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic [1:0]        cfg_data,
  input  wire logic              in_fire,
  input  wire ued_pkg::ued_in_t  in_item,
  output logic                   cmd_valid,
  output ued_pkg::ued_cmd_t      cmd
);
  import ued_pkg::*;

  localparam logic [2:0] PhIdle    = 3'd0;
  localparam logic [2:0] PhUrlPct  = 3'd1;
  localparam logic [2:0] PhUrlHex  = 3'd2;
  localparam logic [2:0] PhCEsc    = 3'd3;
  localparam logic [2:0] PhCHex0   = 3'd4;
  localparam logic [2:0] PhCHex1   = 3'd5;

  logic [1:0] mode;
  logic [2:0] phase, phase_next;
  logic [7:0] held, held_next;
  logic [7:0] b;
  logic       last;

  assign b    = in_item.in_byte;
  assign last = in_item.in_last;

  always_comb begin
    phase_next = PhIdle;
    held_next  = held;
    cmd_valid  = 1'b0;
    cmd        = '0;
    case (phase)
      PhUrlPct: begin
        if (last) begin
          cmd_valid = 1'b1;
          cmd.two   = 1'b1;
          cmd.first = '{out_byte: ChPercent, has_byte: 1'b1, out_last: 1'b0};
          cmd.second = '{out_byte: url_plain(b), has_byte: 1'b1, out_last: 1'b1};
        end else begin
          held_next  = b;
          phase_next = PhUrlHex;
        end
      end
      PhUrlHex, PhCHex1: begin
        cmd_valid = 1'b1;
        cmd.first = '{out_byte: {hex_value(held), hex_value(b)}, has_byte: 1'b1,
                      out_last: last};
      end
      PhCEsc: begin
        if (b == ChX) begin
          if (last) begin
            cmd_valid = 1'b1;
            cmd.first = '{out_byte: 8'h00, has_byte: 1'b1, out_last: 1'b1};
          end else begin
            phase_next = PhCHex0;
          end
        end else begin
          cmd_valid = 1'b1;
          cmd.first = '{out_byte: c_escape_map(b), has_byte: 1'b1, out_last: last};
        end
      end
      PhCHex0: begin
        if (last) begin
          cmd_valid = 1'b1;
          cmd.first = '{out_byte: {hex_value(b), 4'h0}, has_byte: 1'b1, out_last: 1'b1};
        end else begin
          held_next  = b;
          phase_next = PhCHex1;
        end
      end
      default: begin
        if (mode == ModeUrl) begin
          if (b == ChPercent && !last) begin
            phase_next = PhUrlPct;
          end else begin
            cmd_valid = 1'b1;
            cmd.first = '{out_byte: url_plain(b), has_byte: 1'b1, out_last: last};
          end
        end else if (mode == ModeC) begin
          if (b == ChBackslash) begin
            if (last) begin
              cmd_valid = 1'b1;
              cmd.first = '{out_byte: 8'h00, has_byte: 1'b0, out_last: 1'b1};
            end else begin
              phase_next = PhCEsc;
            end
          end else begin
            cmd_valid = 1'b1;
            cmd.first = '{out_byte: b, has_byte: 1'b1, out_last: last};
          end
        end else begin
          cmd_valid = 1'b1;
          cmd.first = '{out_byte: b, has_byte: 1'b1, out_last: last};
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= ModeUrl;
      phase <= PhIdle;
      held  <= 8'h00;
    end else begin
      if (cfg_we) begin
        mode <= cfg_data;
      end
      if (in_fire) begin
        phase <= phase_next;
        held  <= held_next;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/ued_cmd_queue.sv
// ---------------------------------------------------------------------------
// ued_cmd_queue
// Short register queue of decode commands between the front and back parts.
// ---------------------------------------------------------------------------
`default_nettype none

module ued_cmd_queue #(
  parameter int unsigned DEPTH = ued_pkg::CmdQueueDepth
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              wr,
  input  wire ued_pkg::ued_cmd_t wr_data,
  input  wire logic              rd,
  output ued_pkg::ued_cmd_t      rd_data,
  output logic                   full,
  output logic                   empty
);
  import ued_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  ued_cmd_t        mem [DEPTH];
  logic [AW-1:0]   wr_ptr, rd_ptr;
  logic [CW-1:0]   count;
  logic            do_wr, do_rd;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr && !full;
  assign do_rd   = rd && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/ued_back.sv
// ---------------------------------------------------------------------------
// ued_back
// Expands queued commands into single results and holds the oldest result
// in an output register.
// ---------------------------------------------------------------------------
`default_nettype none

module ued_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cmd_empty,
  input  wire ued_pkg::ued_cmd_t cmd,
  output logic                   cmd_rd,
  input  wire logic              pop,
  output logic                   empty,
  output ued_pkg::ued_out_t      out_item
);
  import ued_pkg::*;

  logic     out_valid;
  logic     second;
  ued_out_t out_reg;
  logic     out_free;
  logic     load;

  assign out_free = !out_valid || pop;
  assign load     = out_free && !cmd_empty;
  assign cmd_rd   = load && (second || !cmd.two);
  assign empty    = !out_valid;
  assign out_item = out_reg;

  always_ff @(posedge clk) begin
    if (load) begin
      out_reg <= second ? cmd.second : cmd.first;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      second    <= 1'b0;
    end else begin
      if (out_free) begin
        out_valid <= !cmd_empty;
      end
      // advance to the second half of a two-result command
      if (load) begin
        second <= cmd.two && !second;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/url_and_c_escape_decoder_unit.sv
// ---------------------------------------------------------------------------
// url_and_c_escape_decoder_unit
// Streaming URL percent / C backslash escape decoder, one byte per transfer.
// ---------------------------------------------------------------------------
// channel   handshake         payload
// input     push / full       in_item  (in_byte, in_last)
// result    pop / empty       out_item (out_byte, has_byte, out_last)
// config    cfg_we            cfg_data (decode_mode)
//
// One input byte is taken per cycle unless full is high; the front updates the
// escape state in the same cycle and queues a command of up to two results.
// The back drains one result per cycle while pop is asserted, so a byte ending
// a short percent escape yields an extra result; the command queue absorbs it.
// A result passes the command queue and the output register on its way out.
// Reset clears the escape state and all queued results and sets URL mode.
// full rises only when the command queue is full.
// ---------------------------------------------------------------------------
`default_nettype none

module url_and_c_escape_decoder_unit #(
  parameter int unsigned QUEUE_DEPTH = ued_pkg::CmdQueueDepth
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  output logic                   full,
  input  wire ued_pkg::ued_in_t  in_item,
  output logic                   empty,
  input  wire logic              pop,
  output ued_pkg::ued_out_t      out_item,
  input  wire logic              cfg_we,
  input  wire logic [1:0]        cfg_data
);
  import ued_pkg::*;

  logic     in_fire;
  logic     cmd_valid;
  ued_cmd_t cmd_in;
  ued_cmd_t cmd_head;
  logic     cmd_rd;
  logic     cmd_empty;

  assign in_fire = push && !full;

  ued_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .in_fire   (in_fire),
    .in_item   (in_item),
    .cmd_valid (cmd_valid),
    .cmd       (cmd_in)
  );

  ued_cmd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (in_fire && cmd_valid),
    .wr_data (cmd_in),
    .rd      (cmd_rd),
    .rd_data (cmd_head),
    .full    (full),
    .empty   (cmd_empty)
  );

  ued_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_empty (cmd_empty),
    .cmd       (cmd_head),
    .cmd_rd    (cmd_rd),
    .pop       (pop),
    .empty     (empty),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire
